@@ design/aabb_frustum_cull_test_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frustum cull test block.
// Checks are clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_TEST_ASSERT_SVH
`define AABB_FRUSTUM_CULL_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/afc_pkg.sv @@
// ----------------------------------------------------------------------------
// afc_pkg
// Types and constants of the axis-aligned box versus frustum cull test.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NORMAL_W        = 32;
  localparam int NUM_PLANES      = 6;
  localparam int NUM_AXES        = 3;
  localparam int PLANE_IDX_W     = 3;
  localparam int OP_W            = 2;
  localparam int VIS_W           = 2;
  localparam int USER_W          = OP_W + PLANE_IDX_W;
  localparam int OUT_TDATA_W     = 8;
  localparam int TOL_SHIFT       = 18;
  localparam int ALIGN_SHIFT     = 30;
  localparam int ONE_SHIFT       = 46;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic [APB_ADDR_W-3:0] REG_FRUSTUM_VALID = '0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE       = 2'd0,
    OP_TEST        = 2'd1,
    OP_TEST_NOCULL = 2'd2
  } op_e;

  typedef enum logic [VIS_W-1:0] {
    VIS_OUTSIDE      = 2'd0,
    VIS_INTERSECT    = 2'd1,
    VIS_INSIDE       = 2'd2,
    VIS_CONSERVATIVE = 2'd3
  } vis_e;

endpackage

@@ design/aabb_frustum_cull_test.sv @@
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test
// An accepted test item passes through stage 1, stages 2 to 4 and the output register.
// Throughput: one item per cycle; a five-register pipeline with 36 parallel
// normal-by-coordinate multipliers sets the depth, and stalls only back up.
// A plane write takes effect for every test accepted after it.
// Reset clears the pipeline valid bits and frustum_valid; plane rows are
// undefined until written.
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_test_assert.svh"

module aabb_frustum_cull_test #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF,
  localparam int TdataW = ((3 * afc_pkg::NORMAL_W + 7 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: normal_x, normal_y, normal_z, plane_distance, min_x, min_y, min_z,
  // max_x, max_y, max_z
  input  logic [TdataW-1:0]               s_axis_tdata,
  // tuser: operation, plane_index
  input  logic [afc_pkg::USER_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: visibility
  output logic [afc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [afc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [afc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [afc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import afc_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int PW  = NORMAL_W + CW;
  localparam int SW  = CW + 34;
  localparam int NB  = 3 * NORMAL_W;
  localparam logic signed [SW-1:0] OneQ = SW'(64'd1 << ONE_SHIFT);

  // Configuration register.
  logic frustum_valid_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_FRUSTUM_VALID);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_FRUSTUM_VALID)
                ? {{(APB_DATA_W-1){1'b0}}, frustum_valid_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frustum_valid_q <= 1'b0;
    end else if (cfg_wr) begin
      frustum_valid_q <= pwdata[0];
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, en_o;

  assign en_o = !vo_q || m_axis_tready;
  assign en4  = !v4_q || en_o;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign s_axis_tready = en1;

  // Stage 1: captured item.
  logic [OP_W-1:0]        op1_q;
  logic [PLANE_IDX_W-1:0] idx1_q;
  logic signed [NORMAL_W-1:0] nrm1_q [NUM_AXES];
  logic signed [CW-1:0]   pd1_q;
  logic signed [CW-1:0]   mn1_q [NUM_AXES];
  logic signed [CW-1:0]   mx1_q [NUM_AXES];

  // Plane rows.
  logic signed [NORMAL_W-1:0] normal_q [NUM_PLANES][NUM_AXES];
  logic signed [CW-1:0]       offset_q [NUM_PLANES];

  logic is_test1, is_write1, wr_fire, inverted1, cons2_d;

  always_comb begin
    is_test1  = 1'b0;
    is_write1 = 1'b0;
    case (op1_q)
      OP_WRITE:       is_write1 = 1'b1;
      OP_TEST:        is_test1  = 1'b1;
      OP_TEST_NOCULL: is_test1  = 1'b1;
      default: begin
        is_test1  = 1'b0;
        is_write1 = 1'b0;
      end
    endcase
  end

  assign wr_fire = v1_q && en2 && is_write1;

  always_comb begin
    inverted1 = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (mx1_q[k] < mn1_q[k]) inverted1 = 1'b1;
    end
    cons2_d = !frustum_valid_q || (op1_q == OP_TEST_NOCULL) || inverted1;
  end

  // Stage 2: products of each normal component with the box extents.
  logic signed [PW-1:0] plo2_d [NUM_PLANES][NUM_AXES];
  logic signed [PW-1:0] phi2_d [NUM_PLANES][NUM_AXES];
  logic signed [PW-1:0] plo2_q [NUM_PLANES][NUM_AXES];
  logic signed [PW-1:0] phi2_q [NUM_PLANES][NUM_AXES];
  logic signed [CW-1:0] off2_q [NUM_PLANES];
  logic                 cons2_q;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        plo2_d[p][k] = normal_q[p][k] * mn1_q[k];
        phi2_d[p][k] = normal_q[p][k] * mx1_q[k];
      end
    end
  end

  // Stage 3: per-axis lower, upper and magnitude terms, and the aligned plane offset.
  logic signed [PW-1:0] lt3_d [NUM_PLANES][NUM_AXES];
  logic signed [PW-1:0] ht3_d [NUM_PLANES][NUM_AXES];
  logic        [PW-1:0] mt3_d [NUM_PLANES][NUM_AXES];
  logic signed [SW-1:0] w3_d  [NUM_PLANES];
  logic        [SW-1:0] wa3_d [NUM_PLANES];
  logic signed [PW-1:0] lt3_q [NUM_PLANES][NUM_AXES];
  logic signed [PW-1:0] ht3_q [NUM_PLANES][NUM_AXES];
  logic        [PW-1:0] mt3_q [NUM_PLANES][NUM_AXES];
  logic signed [SW-1:0] w3_q  [NUM_PLANES];
  logic        [SW-1:0] wa3_q [NUM_PLANES];
  logic                 cons3_q;

  always_comb begin
    logic [PW-1:0] aa;
    logic [PW-1:0] ab;
    logic          alb;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        alb = plo2_q[p][k] < phi2_q[p][k];
        aa  = plo2_q[p][k][PW-1] ? PW'(-plo2_q[p][k]) : PW'(plo2_q[p][k]);
        ab  = phi2_q[p][k][PW-1] ? PW'(-phi2_q[p][k]) : PW'(phi2_q[p][k]);
        lt3_d[p][k] = alb ? plo2_q[p][k] : phi2_q[p][k];
        ht3_d[p][k] = alb ? phi2_q[p][k] : plo2_q[p][k];
        mt3_d[p][k] = (aa < ab) ? ab : aa;
      end
      w3_d[p]  = SW'(off2_q[p]) <<< ALIGN_SHIFT;
      wa3_d[p] = off2_q[p][CW-1] ? SW'(-w3_d[p]) : SW'(w3_d[p]);
    end
  end

  // Stage 4: plane distance bounds and magnitude plus one.
  logic signed [SW-1:0] low4_d [NUM_PLANES];
  logic signed [SW-1:0] upp4_d [NUM_PLANES];
  logic signed [SW-1:0] mag4_d [NUM_PLANES];
  logic signed [SW-1:0] low4_q [NUM_PLANES];
  logic signed [SW-1:0] upp4_q [NUM_PLANES];
  logic signed [SW-1:0] mag4_q [NUM_PLANES];
  logic                 cons4_q;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      low4_d[p] = w3_q[p] + SW'(lt3_q[p][0]) + SW'(lt3_q[p][1]) + SW'(lt3_q[p][2]);
      upp4_d[p] = w3_q[p] + SW'(ht3_q[p][0]) + SW'(ht3_q[p][1]) + SW'(ht3_q[p][2]);
      mag4_d[p] = OneQ + $signed(wa3_q[p]) + $signed(SW'(mt3_q[p][0]))
                + $signed(SW'(mt3_q[p][1])) + $signed(SW'(mt3_q[p][2]));
    end
  end

  // Output: tolerance compares and classification.
  logic outside_d, intersect_d;
  vis_e vis_d, vis_q;

  always_comb begin
    logic signed [SW-1:0] tol;
    outside_d   = 1'b0;
    intersect_d = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      tol = mag4_q[p] >>> TOL_SHIFT;
      if (upp4_q[p] < -tol) outside_d = 1'b1;
      if (low4_q[p] <= tol) intersect_d = 1'b1;
    end
    if (cons4_q) begin
      vis_d = VIS_CONSERVATIVE;
    end else if (outside_d) begin
      vis_d = VIS_OUTSIDE;
    end else if (intersect_d) begin
      vis_d = VIS_INTERSECT;
    end else begin
      vis_d = VIS_INSIDE;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= s_axis_tvalid;
      if (en2)  v2_q <= v1_q && is_test1;
      if (en3)  v3_q <= v2_q;
      if (en4)  v4_q <= v3_q;
      if (en_o) vo_q <= v4_q;
    end
  end

  // Payload registers and plane rows.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q  <= s_axis_tuser[OP_W-1:0];
      idx1_q <= s_axis_tuser[USER_W-1:OP_W];
      for (int k = 0; k < NUM_AXES; k++) begin
        nrm1_q[k] <= s_axis_tdata[k*NORMAL_W +: NORMAL_W];
        mn1_q[k]  <= s_axis_tdata[NB + (1 + k) * CW +: CW];
        mx1_q[k]  <= s_axis_tdata[NB + (4 + k) * CW +: CW];
      end
      pd1_q <= s_axis_tdata[NB +: CW];
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (wr_fire && (idx1_q == PLANE_IDX_W'(p))) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          normal_q[p][k] <= nrm1_q[k];
        end
        offset_q[p] <= pd1_q;
      end
    end
    if (en2) begin
      plo2_q  <= plo2_d;
      phi2_q  <= phi2_d;
      off2_q  <= offset_q;
      cons2_q <= cons2_d;
    end
    if (en3) begin
      lt3_q   <= lt3_d;
      ht3_q   <= ht3_d;
      mt3_q   <= mt3_d;
      w3_q    <= w3_d;
      wa3_q   <= wa3_d;
      cons3_q <= cons2_q;
    end
    if (en4) begin
      low4_q  <= low4_d;
      upp4_q  <= upp4_d;
      mag4_q  <= mag4_d;
      cons4_q <= cons3_q;
    end
    if (en_o) begin
      vis_q <= vis_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-VIS_W){1'b0}}, vis_q};

  logic adv1_test, adv1_other;
  assign adv1_test  = v1_q && en2 && is_test1 && (op1_q inside {OP_TEST, OP_TEST_NOCULL});
  assign adv1_other = v1_q && en2 && !is_test1;

  `AFC_ASSERT_IMP(a_ready_when_out_empty, !vo_q, s_axis_tready, "input stalled with empty output")
  `AFC_ASSERT_NXT(a_no_result_for_write, adv1_other, !v2_q, "write item entered the datapath")
  `AFC_ASSERT_NXT(a_last_stage_delivers, v4_q && en_o, vo_q, "result lost at the output stage")
  `AFC_ASSERT_NXT(a_cons_when_invalid, adv1_test && !frustum_valid_q, cons2_q,
                  "test without valid frustum not marked conservative")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum cull test bench
// Loads six planes, then walks a short table of directed items and a long
// random stream of plane writes and box tests through the block. Each
// visibility answer is compared with a behavioral predictor of the plane
// arithmetic, or with the value a directed row gives. Random gaps and stalls on both streams cover the handshake.
// ----------------------------------------------------------------------------
module tb_top;
  import afc_pkg::*;

  localparam int TDATA_W = ((3 * NORMAL_W + 7 * COORD_WIDTH_DEF + 7) / 8) * 8;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic [31:0] N_ONE  = 32'h4000_0000;
  localparam logic [31:0] N_MONE = 32'hC000_0000;
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_R    = 32'h0064_0000;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [2:0]         idx;
    logic [TDATA_W-1:0] data;
    bit                 typed;
    vis_e               vis;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // tdata: normal_x, normal_y, normal_z, plane_distance, min_x, min_y, min_z,
  // max_x, max_y, max_z
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  // tuser: operation, plane_index
  logic [USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // tdata: visibility
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic [31:0] normal_store [NUM_PLANES*NUM_AXES];
  logic [31:0] offset_store [NUM_PLANES];
  logic        frustum_on = 1'b0;
  logic [1:0]  expected_vis_q [$];
  int          error_count = 0;
  int          idle_mode = 0;
  bit          hold_req = 1'b0;
  bit          cur_typed = 1'b0;
  vis_e        cur_typed_vis = VIS_OUTSIDE;

  aabb_frustum_cull_test i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [1:0] predict_visibility(input logic [USER_W-1:0] user,
                                                    input logic [TDATA_W-1:0] data,
                                                    output bit produces);
    logic [OP_W-1:0] op;
    logic [2:0] idx;
    logic signed [31:0] lo_c [NUM_AXES];
    logic signed [31:0] hi_c [NUM_AXES];
    logic signed [31:0] n;
    logic signed [127:0] a, b, lower, upper, mag, tol;
    bit outside, touches;
    op = user[OP_W-1:0];
    idx = user[USER_W-1:OP_W];
    produces = 1'b0;
    if (op == OP_WRITE) begin
      if (idx < NUM_PLANES) begin
        for (int k = 0; k < NUM_AXES; k++) normal_store[idx*NUM_AXES+k] = data[32*k +: 32];
        offset_store[idx] = data[96 +: 32];
      end
      return VIS_CONSERVATIVE;
    end
    if (op == OP_RESERVED) return VIS_CONSERVATIVE;
    produces = 1'b1;
    if (!frustum_on || op == OP_TEST_NOCULL) return VIS_CONSERVATIVE;
    for (int k = 0; k < NUM_AXES; k++) begin
      lo_c[k] = data[128 + 32*k +: 32];
      hi_c[k] = data[224 + 32*k +: 32];
      if (hi_c[k] < lo_c[k]) return VIS_CONSERVATIVE;
    end
    outside = 1'b0;
    touches = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      lower = $signed(offset_store[p]);
      lower = lower <<< ALIGN_SHIFT;
      upper = lower;
      mag = (lower < 0) ? -lower : lower;
      for (int k = 0; k < NUM_AXES; k++) begin
        n = normal_store[p*NUM_AXES+k];
        a = n * lo_c[k];
        b = n * hi_c[k];
        if (a < b) begin
          lower += a;
          upper += b;
        end else begin
          lower += b;
          upper += a;
        end
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        mag += (a < b) ? b : a;
      end
      tol = ((128'sd1 <<< ONE_SHIFT) + mag) >>> TOL_SHIFT;
      if (upper < -tol) outside = 1'b1;
      if (lower <= tol) touches = 1'b1;
    end
    return outside ? VIS_OUTSIDE : (touches ? VIS_INTERSECT : VIS_INSIDE);
  endfunction

  function automatic stim_row_t mk_row(input logic [OP_W-1:0] op, input logic [2:0] idx,
                                       input logic [31:0] nx, ny, nz, w,
                                       input logic [31:0] x0, y0, z0, x1, y1, z1,
                                       input bit typed, input vis_e vis);
    stim_row_t r;
    r.op = op;
    r.idx = idx;
    r.data = '0;
    r.data[319:0] = {z1, y1, x1, z0, y0, x0, w, nz, ny, nx};
    r.typed = typed;
    r.vis = vis;
    return r;
  endfunction

  function automatic void make_random_item(output logic [USER_W-1:0] user,
                                           output logic [TDATA_W-1:0] data);
    logic [31:0] f [10];
    logic [31:0] c, h, t;
    logic [OP_W-1:0] op;
    logic [2:0] idx;
    int unsigned pick, shape, axis;
    for (int i = 0; i < 10; i++) f[i] = $urandom;
    idx = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 10) begin
      op = OP_WRITE;
      idx = ($urandom_range(9) == 0) ? 3'(6 + $urandom_range(1)) : 3'($urandom_range(5));
      if ($urandom_range(4) != 0) begin
        // Mostly near-axis planes with a positive offset, so the planes enclose a
        // region and boxes land inside, outside and across the boundary.
        axis = $urandom_range(2);
        for (int k = 0; k < NUM_AXES; k++) f[k] = 32'($urandom_range(0, 2000)) - 32'd1000;
        f[axis] = $urandom_range(1) ? N_ONE : N_MONE;
        f[3] = $urandom_range(32'h0001_0000, 32'h07D0_0000);
      end else begin
        for (int k = 0; k < NUM_AXES; k++) f[k] = $urandom_range(0, 32'h8000_0000) - N_ONE;
      end
    end else begin
      op = (pick < 82) ? OP_TEST : ((pick < 94) ? OP_TEST_NOCULL : OP_RESERVED);
      for (int k = 0; k < NUM_AXES; k++) f[k] = $urandom_range(0, 32'h8000_0000) - N_ONE;
      shape = $urandom_range(19);
      if (shape < 16) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          c = $urandom_range(0, 32'h1770_0000) - 32'h0BB8_0000;
          h = $urandom_range(0, 32'h05DC_0000);
          f[4+k] = c - h;
          f[7+k] = c + h;
        end
        if (shape == 0) begin
          axis = $urandom_range(2);
          t = f[4+axis];
          f[4+axis] = f[7+axis];
          f[7+axis] = t;
        end
      end else if (shape == 19) begin
        for (int k = 0; k < 6; k++) begin
          case ($urandom_range(3))
            0: f[4+k] = Q_MIN;
            1: f[4+k] = Q_MAX;
            2: f[4+k] = '0;
            default: f[4+k] = '1;
          endcase
        end
        for (int k = 0; k < NUM_AXES; k++) begin
          if ($signed(f[7+k]) < $signed(f[4+k]) && $urandom_range(3) != 0) begin
            t = f[4+k];
            f[4+k] = f[7+k];
            f[7+k] = t;
          end
        end
      end
    end
    data = '0;
    for (int i = 0; i < 10; i++) data[32*i +: 32] = f[i];
    user = {idx, op};
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 27;
      1: return $urandom_range(99) < 72;
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_item(input logic [USER_W-1:0] user, input logic [TDATA_W-1:0] data,
                           input bit typed, input vis_e vis);
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= user;
    s_axis_tdata <= data;
    cur_typed <= typed;
    cur_typed_vis <= vis;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cur_typed <= 1'b0;
    @(posedge clk_i);
    while (expected_vis_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_FRUSTUM_VALID, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frustum_valid(input logic v);
    logic [APB_DATA_W-1:0] rd;
    drain();
    apb_access(1'b1, APB_DATA_W'(v), rd);
    frustum_on = v;
    apb_access(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(v)) begin
      $display("%0t: frustum_valid read expected %0h, got %0h", $time, v, rd);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    logic [1:0] vis;
    logic [1:0] want;
    bit produces;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_vis_q.size() == 0) begin
        $display("%0t: visibility expected none, got %0h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_vis_q.pop_front();
        if (m_axis_tdata !== OUT_TDATA_W'(want)) begin
          $display("%0t: visibility expected %0h, got %0h", $time, want, m_axis_tdata);
          error_count++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      vis = predict_visibility(s_axis_tuser, s_axis_tdata, produces);
      if (produces) expected_vis_q.push_back(cur_typed ? cur_typed_vis : vis);
    end
  end

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (idle_mode)
          0: m_axis_tready <= ($urandom_range(99) >= 72);
          1: m_axis_tready <= ($urandom_range(99) >= 27);
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    stim_row_t pre_rows [$];
    stim_row_t post_rows [$];
    logic [USER_W-1:0] u;
    logic [TDATA_W-1:0] d;
    int chunk_valid [4];
    int chunk_mode [4];
    int chunk_len [4];
    chunk_valid = '{1, 0, 1, 1};
    chunk_mode = '{0, 1, 1, 2};
    chunk_len = '{700, 100, 600, 550};

    // Axis-aligned cube of half size 100.0, then tests while the frustum is off.
    pre_rows.push_back(mk_row(OP_WRITE, 0, N_ONE, 0, 0, Q_R, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    pre_rows.push_back(mk_row(OP_WRITE, 1, N_MONE, 0, 0, Q_R, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    pre_rows.push_back(mk_row(OP_WRITE, 2, 0, N_ONE, 0, Q_R, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    pre_rows.push_back(mk_row(OP_WRITE, 3, 0, N_MONE, 0, Q_R, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    pre_rows.push_back(mk_row(OP_WRITE, 4, 0, 0, N_ONE, Q_R, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    pre_rows.push_back(mk_row(OP_WRITE, 5, 0, 0, N_MONE, Q_R, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    pre_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, 32'hFFF6_0000, 32'hFFF6_0000,
                              32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
                              1, VIS_CONSERVATIVE));
    pre_rows.push_back(mk_row(OP_TEST_NOCULL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                              1, VIS_CONSERVATIVE));
    pre_rows.push_back(mk_row(OP_RESERVED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    pre_rows.push_back(mk_row(OP_WRITE, 6, N_MONE, N_MONE, N_MONE, Q_MIN, 0, 0, 0, 0, 0, 0,
                              0, VIS_OUTSIDE));
    pre_rows.push_back(mk_row(OP_WRITE, 7, N_ONE, N_ONE, N_ONE, Q_MIN, 0, 0, 0, 0, 0, 0,
                              0, VIS_OUTSIDE));

    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, 32'hFFF6_0000, 32'hFFF6_0000,
                               32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
                               0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, 32'h00C8_0000, 0, 0, 32'h012C_0000,
                               0, 0, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, 32'h0032_0000, 0, 0, 32'h0096_0000,
                               0, 0, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, Q_R, 0, 0, Q_R, 0, 0, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, 32'h000A_0000, 0, 0, 32'hFFF6_0000,
                               0, 0, 1, VIS_CONSERVATIVE));
    post_rows.push_back(mk_row(OP_TEST_NOCULL, 0, 0, 0, 0, 0, 32'hFFF6_0000, 32'hFFF6_0000,
                               32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000,
                               1, VIS_CONSERVATIVE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX,
                               Q_MAX, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                               Q_MAX, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                               Q_MIN, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_RESERVED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_WRITE, 5, N_MONE, N_MONE, N_MONE, Q_MIN, 0, 0, 0, 0, 0, 0,
                               0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX,
                               Q_MAX, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_WRITE, 5, N_ONE, N_ONE, N_ONE, Q_MAX, 0, 0, 0, 0, 0, 0,
                               0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX,
                               Q_MAX, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, VIS_OUTSIDE));
    post_rows.push_back(mk_row(OP_WRITE, 5, 0, 0, N_MONE, Q_R, 0, 0, 0, 0, 0, 0, 0,
                               VIS_OUTSIDE));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_mode = 0;
    foreach (pre_rows[i]) begin
      send_item({pre_rows[i].idx, pre_rows[i].op}, pre_rows[i].data, pre_rows[i].typed,
                pre_rows[i].vis);
    end
    set_frustum_valid(1'b1);
    foreach (post_rows[i]) begin
      send_item({post_rows[i].idx, post_rows[i].op}, post_rows[i].data, post_rows[i].typed,
                post_rows[i].vis);
    end

    for (int c = 0; c < 4; c++) begin
      set_frustum_valid(chunk_valid[c][0]);
      idle_mode = chunk_mode[c];
      // Without idling the sender keeps offering while the sink holds off,
      // so the pipeline fills and input backpressure is exercised.
      if (chunk_mode[c] == 2) hold_req = 1'b1;
      repeat (chunk_len[c]) begin
        make_random_item(u, d);
        send_item(u, d, 1'b0, VIS_OUTSIDE);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/afc_pkg.sv
design/aabb_frustum_cull_test.sv
dv/tb_top.sv
